/* hdl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, widths, register codes and reset values of the sphere
// frustum cull test.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  // default coordinate format, Q13.8 in 21 bits
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int COORD_WIDTH_DEF     = 21;

  // fixed field widths
  localparam int AXIS_W   = 16;
  localparam int AXES_W   = 3 * AXIS_W;
  localparam int TAN_W    = 24;
  localparam int RATIO_W  = 16;
  localparam int FACTOR_W = 16;
  localparam int SCALE_W  = 12;

  // fraction bits of the fixed formats
  localparam int TAN_FRAC    = 16;
  localparam int RATIO_FRAC  = 12;
  localparam int FACTOR_FRAC = 12;
  localparam int AXIS_FRAC   = 14;
  localparam int SQRT2_FRAC  = 30;

  // sqrt(2) as unsigned Q1.30
  localparam int SQRT2_W = 31;
  localparam logic [SQRT2_W-1:0] SQRT2_Q30 = 31'd1518500250;

  // configuration port
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;
  localparam int IDX_LSB = 3;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_UP     = 3'd2,
    REG_VIEW   = 3'd3,
    REG_TAN    = 3'd4,
    REG_RATIO  = 3'd5,
    REG_FACTOR = 3'd6
  } reg_idx_t;

  // reset values
  localparam logic [AXES_W-1:0]   RIGHT_RST  = 48'h0000_0000_4000;
  localparam logic [AXES_W-1:0]   UP_RST     = 48'h0000_4000_0000;
  localparam logic [AXES_W-1:0]   VIEW_RST   = 48'h4000_0000_0000;
  localparam logic [TAN_W-1:0]    TAN_RST    = 24'h01_0000;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 16'h1000;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'h1000;

  // camera set-up held by the register file
  typedef struct packed {
    logic [AXES_W-1:0]   right_axis;
    logic [AXES_W-1:0]   up_axis;
    logic [AXES_W-1:0]   view_axis;
    logic [TAN_W-1:0]    tan_half_fov;
    logic [RATIO_W-1:0]  aspect_ratio;
    logic [FACTOR_W-1:0] sphere_factor;
  } cam_cfg_t;

endpackage

`default_nettype wire

/* hdl/sfc_regs.sv */
// ----------------------------------------------------------------------------
// sfc_regs
// APB-style register file holding the camera position, axes and cone set-up.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_regs #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sfc_pkg::DATA_W-1:0]   pwdata,
  output logic      [sfc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic      [3*COORD_WIDTH-1:0]     camera_position,
  output sfc_pkg::cam_cfg_t                 cfg
);
  import sfc_pkg::*;

  localparam int CAM_W = 3 * COORD_WIDTH;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[IDX_LSB +: IDX_W]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_position   <= '0;
      cfg.right_axis    <= RIGHT_RST;
      cfg.up_axis       <= UP_RST;
      cfg.view_axis     <= VIEW_RST;
      cfg.tan_half_fov  <= TAN_RST;
      cfg.aspect_ratio  <= RATIO_RST;
      cfg.sphere_factor <= FACTOR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CAMERA: camera_position   <= pwdata[CAM_W-1:0];
        REG_RIGHT:  cfg.right_axis    <= pwdata[AXES_W-1:0];
        REG_UP:     cfg.up_axis       <= pwdata[AXES_W-1:0];
        REG_VIEW:   cfg.view_axis     <= pwdata[AXES_W-1:0];
        REG_TAN:    cfg.tan_half_fov  <= pwdata[TAN_W-1:0];
        REG_RATIO:  cfg.aspect_ratio  <= pwdata[RATIO_W-1:0];
        REG_FACTOR: cfg.sphere_factor <= pwdata[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CAMERA: prdata = DATA_W'(camera_position);
      REG_RIGHT:  prdata = DATA_W'(cfg.right_axis);
      REG_UP:     prdata = DATA_W'(cfg.up_axis);
      REG_VIEW:   prdata = DATA_W'(cfg.view_axis);
      REG_TAN:    prdata = DATA_W'(cfg.tan_half_fov);
      REG_RATIO:  prdata = DATA_W'(cfg.aspect_ratio);
      REG_FACTOR: prdata = DATA_W'(cfg.sphere_factor);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/sphere_frustum_cull_test_unit.sv */
// ----------------------------------------------------------------------------
// sphere_frustum_cull_test_unit
// Sphere against view cone culling test for one cube per cycle.
// ----------------------------------------------------------------------------
// A cube (centre and whole-unit scale) is taken whenever start is high; busy
// stays low, so one cube enters every clock cycle. Each cube gives exactly one
// result, visible, shown with done high for one cycle, in the order the cubes
// came in. The receiver cannot stall the result; it passes through the
// pipeline stages: offset, axis products, projection sums, depth times
// tangent in two partial products, their recombination, aspect product in two
// partial products, its recombination with the vertical test, and the side
// test. Camera registers are to be written by the user through the APB-style
// port only while no cube is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_cull_test_unit #(
  parameter int COORD_FRAC_BITS = sfc_pkg::COORD_FRAC_BITS_DEF,
  parameter int COORD_WIDTH     = sfc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] center_x,
  input  wire logic signed [COORD_WIDTH-1:0] center_y,
  input  wire logic signed [COORD_WIDTH-1:0] center_z,
  input  wire logic [sfc_pkg::SCALE_W-1:0]   cube_scale,
  output logic                               done,
  output logic                               visible,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [sfc_pkg::DATA_W-1:0]    pwdata,
  output logic      [sfc_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);
  import sfc_pkg::*;

  // internal widths
  localparam int V_W      = COORD_WIDTH + 1;
  localparam int PROD_W   = V_W + AXIS_W;
  localparam int PROJ_W   = PROD_W + 2;
  localparam int LO_W     = PROJ_W / 2;
  localparam int HI_W     = PROJ_W - LO_W;
  localparam int LO_P_W   = LO_W + TAN_W;
  localparam int HI_P_W   = HI_W + TAN_W + 1;
  localparam int FULL_W   = PROJ_W + TAN_W + 1;
  localparam int DT_W     = FULL_W - TAN_FRAC;
  localparam int DT_LO_W  = DT_W / 2;
  localparam int DT_HI_W  = DT_W - DT_LO_W;
  localparam int SL_P_W   = DT_LO_W + RATIO_W;
  localparam int SH_P_W   = DT_HI_W + RATIO_W + 1;
  localparam int SIDE_P_W = DT_W + RATIO_W + 1;
  localparam int SIDE_W   = SIDE_P_W - RATIO_FRAC;
  localparam int RP_W     = SCALE_W + SQRT2_W;
  localparam int RAD_SH   = SQRT2_FRAC - AXIS_FRAC - COORD_FRAC_BITS;
  localparam int RAD_W    = RP_W - RAD_SH;
  localparam int SP_P_W   = RAD_W + FACTOR_W;
  localparam int SP_W     = SP_P_W - FACTOR_FRAC;
  localparam int M1_W     = (SIDE_W > SP_W + 1) ? SIDE_W : SP_W + 1;
  localparam int M2_W     = (M1_W > PROJ_W) ? M1_W : PROJ_W;
  localparam int CMP_W    = M2_W + 2;
  localparam int DEPTH    = 8;

  logic [3*COORD_WIDTH-1:0] camera_position;
  cam_cfg_t                 cfg;

  // configuration registers
  sfc_regs #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .camera_position(camera_position),
    .cfg(cfg)
  );

  assign busy = 1'b0;

  // valid bits travelling with the data
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], start};
    end
  end

  assign done = vld[DEPTH-1];

  // unpacked inputs and set-up
  logic signed [COORD_WIDTH-1:0] cen [3];
  logic signed [COORD_WIDTH-1:0] cam [3];
  logic signed [AXIS_W-1:0]      axis [3][3];
  logic        [RP_W-1:0]        rad_p;

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cam[k]     = $signed(camera_position[k*COORD_WIDTH +: COORD_WIDTH]);
      axis[0][k] = $signed(cfg.right_axis[k*AXIS_W +: AXIS_W]);
      axis[1][k] = $signed(cfg.up_axis[k*AXIS_W +: AXIS_W]);
      axis[2][k] = $signed(cfg.view_axis[k*AXIS_W +: AXIS_W]);
    end
  end

  assign rad_p = RP_W'(cube_scale) * RP_W'(SQRT2_Q30);

  // stage 1: offset from camera and bounding radius
  logic signed [V_W-1:0] s1_v [3];
  logic        [RAD_W-1:0] s1_rad;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_v[k] <= V_W'(cen[k]) - V_W'(cam[k]);
    end
    s1_rad <= rad_p[RP_W-1:RAD_SH];
  end

  // stage 2: axis products and radius spread
  logic signed [PROD_W-1:0] s2_p [3][3];
  logic        [SP_P_W-1:0] sp_p;
  logic        [SP_W-1:0]   s2_sp;

  assign sp_p = SP_P_W'(cfg.sphere_factor) * SP_P_W'(s1_rad);

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        s2_p[a][k] <= PROD_W'(s1_v[k]) * PROD_W'(axis[a][k]);
      end
    end
    s2_sp <= sp_p[SP_P_W-1:FACTOR_FRAC];
  end

  // stage 3: projections onto right, up and view axes
  logic signed [PROJ_W-1:0] s3_ax, s3_ay, s3_az;
  logic        [SP_W-1:0]   s3_sp;

  always_ff @(posedge clk) begin
    s3_ax <= PROJ_W'(s2_p[0][0]) + PROJ_W'(s2_p[0][1]) + PROJ_W'(s2_p[0][2]);
    s3_ay <= PROJ_W'(s2_p[1][0]) + PROJ_W'(s2_p[1][1]) + PROJ_W'(s2_p[1][2]);
    s3_az <= PROJ_W'(s2_p[2][0]) + PROJ_W'(s2_p[2][1]) + PROJ_W'(s2_p[2][2]);
    s3_sp <= s2_sp;
  end

  // stage 4: depth times tangent as two partial products
  logic signed [HI_W-1:0]    az_hi;
  logic        [LO_W-1:0]    az_lo;
  logic signed [TAN_W:0]     tan_s;
  logic signed [HI_P_W-1:0]  s4_hi_p;
  logic        [LO_P_W-1:0]  s4_lo_p;
  logic signed [PROJ_W-1:0]  s4_ax, s4_ay;
  logic        [SP_W-1:0]    s4_sp;

  assign az_hi = s3_az[PROJ_W-1:LO_W];
  assign az_lo = s3_az[LO_W-1:0];
  assign tan_s = $signed({1'b0, cfg.tan_half_fov});

  always_ff @(posedge clk) begin
    s4_hi_p <= HI_P_W'(az_hi) * HI_P_W'(tan_s);
    s4_lo_p <= LO_P_W'(az_lo) * LO_P_W'(cfg.tan_half_fov);
    s4_ax   <= s3_ax;
    s4_ay   <= s3_ay;
    s4_sp   <= s3_sp;
  end

  // stage 5: recombine and floor to depth_tan
  logic signed [FULL_W-1:0] full_p;
  logic signed [DT_W-1:0]   s5_dt;
  logic signed [PROJ_W-1:0] s5_ax, s5_ay;
  logic        [SP_W-1:0]   s5_sp;

  assign full_p = (FULL_W'(s4_hi_p) <<< LO_W) + $signed(FULL_W'(s4_lo_p));

  always_ff @(posedge clk) begin
    s5_dt <= $signed(full_p[FULL_W-1:TAN_FRAC]);
    s5_ax <= s4_ax;
    s5_ay <= s4_ay;
    s5_sp <= s4_sp;
  end

  // stage 6: aspect product as two partial products, vertical limit and
  // side offsets moved across the spread
  logic signed [DT_HI_W-1:0] dt_hi;
  logic        [DT_LO_W-1:0] dt_lo;
  logic signed [RATIO_W:0]   ratio_s;
  logic signed [CMP_W-1:0]   ax_w;
  logic signed [CMP_W-1:0]   sp_w;
  logic signed [SH_P_W-1:0]  s6_hi_p;
  logic        [SL_P_W-1:0]  s6_lo_p;
  logic signed [CMP_W-1:0]   s6_max_y;
  logic signed [CMP_W-1:0]   s6_ax_m, s6_ax_n;
  logic signed [PROJ_W-1:0]  s6_ay;

  assign dt_hi   = s5_dt[DT_W-1:DT_LO_W];
  assign dt_lo   = s5_dt[DT_LO_W-1:0];
  assign ratio_s = $signed({1'b0, cfg.aspect_ratio});
  assign ax_w    = CMP_W'(s5_ax);
  assign sp_w    = $signed(CMP_W'(s5_sp));

  always_ff @(posedge clk) begin
    s6_hi_p  <= SH_P_W'(dt_hi) * SH_P_W'(ratio_s);
    s6_lo_p  <= SL_P_W'(dt_lo) * SL_P_W'(cfg.aspect_ratio);
    s6_max_y <= CMP_W'(s5_dt) + sp_w;
    s6_ax_m  <= ax_w - sp_w;
    s6_ax_n  <= -ax_w - sp_w;
    s6_ay    <= s5_ay;
  end

  // stage 7: side reach recombined and vertical test
  logic signed [SIDE_P_W-1:0] side_p;
  logic signed [CMP_W-1:0]    ay_w;
  logic signed [SIDE_W-1:0]   s7_side;
  logic signed [CMP_W-1:0]    s7_ax_m, s7_ax_n;
  logic                       s7_y_in;

  assign side_p = (SIDE_P_W'(s6_hi_p) <<< DT_LO_W) + $signed(SIDE_P_W'(s6_lo_p));
  assign ay_w   = CMP_W'(s6_ay);

  always_ff @(posedge clk) begin
    s7_side <= $signed(side_p[SIDE_P_W-1:RATIO_FRAC]);
    s7_ax_m <= s6_ax_m;
    s7_ax_n <= s6_ax_n;
    s7_y_in <= !((ay_w > s6_max_y) || ((ay_w + s6_max_y) < 0));
  end

  // stage 8: side test and result register
  logic signed [CMP_W-1:0] side_w;

  assign side_w = CMP_W'(s7_side);

  always_ff @(posedge clk) begin
    visible <= s7_y_in && !((s7_ax_m > side_w) || (s7_ax_n > side_w));
  end

endmodule

`default_nettype wire
